### sv/oht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oven thermostat package
// Payload structs, register indexes, operation codes and reset values that
// the relay controller uses.
// ----------------------------------------------------------------------------
package oht_pkg;

   localparam int TEMP_WIDTH = 12;
   localparam int STEP_WIDTH = 9;
   localparam int LIMIT_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 16;

   typedef logic [TEMP_WIDTH-1:0] temp_type;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_BUTTON = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_STEP_SIZE   = 3'd0,
      CSR_FLOOR       = 3'd1,
      CSR_CEILING     = 3'd2,
      CSR_FAIL_LIMIT  = 3'd3,
      CSR_COMMIT_DLY  = 3'd4,
      CSR_PRESET_LOW  = 3'd5,
      CSR_PRESET_MID  = 3'd6,
      CSR_PRESET_HIGH = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [1:0] operation;
      temp_type   sample;
      logic       sensor_fault;
      logic       button;
      logic       click_kind;
   } oht_req_type;

   typedef struct packed {
      logic     relay_on;
      logic     halted;
      temp_type active_setpoint;
      temp_type edited_setpoint;
   } oht_rsp_type;

   // Button and click codes
   localparam logic BUTTON_MINUS = 1'b1;
   localparam logic CLICK_JUMP = 1'b1;

   // Hysteresis offsets, quarter degrees
   localparam logic [TEMP_WIDTH:0] OFF_MARGIN = (TEMP_WIDTH+1)'(4);
   localparam logic [TEMP_WIDTH:0] REARM_MARGIN = (TEMP_WIDTH+1)'(16);

   // Reset values
   localparam logic [STEP_WIDTH-1:0] RST_STEP_SIZE = 9'd4;
   localparam temp_type RST_FLOOR = 12'd0;
   localparam temp_type RST_CEILING = 12'd1200;
   localparam logic [LIMIT_WIDTH-1:0] RST_FAIL_LIMIT = 16'd5000;
   localparam logic [LIMIT_WIDTH-1:0] RST_COMMIT_DLY = 16'd3000;
   localparam temp_type RST_PRESET_LOW = 12'd720;
   localparam temp_type RST_PRESET_MID = 12'd800;
   localparam temp_type RST_PRESET_HIGH = 12'd880;
   localparam temp_type RST_SETPOINT = 12'd80;

endpackage

### sv/oven_hysteresis_thermostat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oven hysteresis thermostat
// Bang-bang relay control with two-phase hysteresis, failsafe halt and a
// button-edited setpoint that commits after an idle timeout.
//
//   channel  direction  ports                              transfer when
//   req      in         req_valid, req_ready, req_data     valid & ready
//   rsp      out        rsp_valid, rsp_ready, rsp_data     valid & ready
//   csr      in         csr_we, csr_index, csr_wdata       csr_we
//
// One event per cycle while req_ready is high: each transfer updates the state
// registers and loads the result register in the same clock.
// The result register is the only stage; req_ready stays high while it is
// empty or being emptied, so a stalled consumer holds the block one-for-one.
// Reset is synchronous and returns every state and configuration register to
// its power-up value.
// ----------------------------------------------------------------------------
module oven_hysteresis_thermostat
   import oht_pkg::*;
#(
   parameter int COUNTER_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  oht_req_type                req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output oht_rsp_type                rsp_data,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int CMP_W = (COUNTER_WIDTH > LIMIT_WIDTH) ? COUNTER_WIDTH : LIMIT_WIDTH;
   localparam int SUM_W = TEMP_WIDTH + 1;

   typedef logic [COUNTER_WIDTH-1:0] count_type;

   // configuration
   logic [STEP_WIDTH-1:0]  step_size_ff;
   temp_type               floor_ff, ceiling_ff;
   logic [LIMIT_WIDTH-1:0] fail_limit_ff, commit_dly_ff;
   temp_type               preset_low_ff, preset_mid_ff, preset_high_ff;

   // control state
   temp_type  committed_ff, committed_in;
   temp_type  edit_ff, edit_in;
   logic      hyst_ff, hyst_in;
   logic      relay_ff, relay_in;
   logic      halt_ff, halt_in;
   count_type invalid_ff, invalid_in;
   count_type idle_ff, idle_in;

   // result register
   logic        rsp_valid_ff;
   oht_rsp_type rsp_data_ff, rsp_data_in;

   logic        req_fire;
   op_type      op;
   logic        sample_ok;
   logic [SUM_W-1:0] smp_ext, cp_ext;
   logic [SUM_W-1:0] plus_sum, floor_sum;
   temp_type    pick_up, pick_down, step_pt;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign op        = op_type'(req_data.operation);
   assign sample_ok = !req_data.sensor_fault && (req_data.sample != '0);
   assign smp_ext   = SUM_W'(req_data.sample);
   assign cp_ext    = SUM_W'(committed_ff);
   assign plus_sum  = SUM_W'(edit_ff) + SUM_W'(step_size_ff);
   assign floor_sum = SUM_W'(floor_ff) + SUM_W'(step_size_ff);

   // Next preset above / below the committed point, presets compared as given
   always_comb begin
      if (committed_ff >= preset_high_ff) begin
         pick_up = committed_ff;
      end else if (committed_ff < preset_low_ff) begin
         pick_up = preset_low_ff;
      end else if (committed_ff < preset_mid_ff) begin
         pick_up = preset_mid_ff;
      end else if (committed_ff >= preset_mid_ff) begin
         pick_up = preset_high_ff;
      end else begin
         pick_up = committed_ff;
      end
      if (committed_ff <= preset_low_ff) begin
         pick_down = committed_ff;
      end else if (committed_ff > preset_high_ff) begin
         pick_down = preset_high_ff;
      end else if (committed_ff <= preset_mid_ff) begin
         pick_down = preset_low_ff;
      end else if (committed_ff > preset_mid_ff) begin
         pick_down = preset_mid_ff;
      end else begin
         pick_down = committed_ff;
      end
   end

   // Step click, clamped only in the direction of travel
   always_comb begin
      if (req_data.button != BUTTON_MINUS) begin
         step_pt = (plus_sum > SUM_W'(ceiling_ff)) ? ceiling_ff : plus_sum[TEMP_WIDTH-1:0];
      end else begin
         step_pt = (SUM_W'(edit_ff) < floor_sum) ? floor_ff
                                                 : edit_ff - TEMP_WIDTH'(step_size_ff);
      end
   end

   always_comb begin
      committed_in = committed_ff;
      edit_in      = edit_ff;
      hyst_in      = hyst_ff;
      relay_in     = relay_ff;
      halt_in      = halt_ff;
      invalid_in   = invalid_ff;
      idle_in      = idle_ff;
      if (!halt_ff) begin
         case (op)
            OP_TICK: begin
               invalid_in = (invalid_ff == '1) ? invalid_ff
                                               : invalid_ff + COUNTER_WIDTH'(1);
               idle_in    = (idle_ff == '1) ? idle_ff : idle_ff + COUNTER_WIDTH'(1);
            end
            OP_SAMPLE: begin
               if (sample_ok) begin
                  invalid_in = '0;
                  if (!hyst_ff) begin
                     if (smp_ext + OFF_MARGIN < cp_ext) begin
                        relay_in = 1'b1;
                     end else begin
                        relay_in = 1'b0;
                        hyst_in  = 1'b1;
                     end
                  end else if (smp_ext + REARM_MARGIN <= cp_ext) begin
                     hyst_in = 1'b0;
                  end
               end
               if (CMP_W'(invalid_in) >= CMP_W'(fail_limit_ff)) begin
                  halt_in  = 1'b1;
                  relay_in = 1'b0;
               end
            end
            OP_BUTTON: begin
               if (req_data.click_kind == CLICK_JUMP) begin
                  edit_in = (req_data.button == BUTTON_MINUS) ? pick_down : pick_up;
               end else begin
                  edit_in = step_pt;
               end
               idle_in = '0;
            end
            default: begin
            end
         endcase
         // commit the edit once the panel has been left alone long enough
         if (!halt_in && (CMP_W'(idle_in) >= CMP_W'(commit_dly_ff))) begin
            committed_in = edit_in;
         end
      end
      rsp_data_in.relay_on        = relay_in && !halt_in;
      rsp_data_in.halted          = halt_in;
      rsp_data_in.active_setpoint = committed_in;
      rsp_data_in.edited_setpoint = edit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff   <= RST_STEP_SIZE;
         floor_ff       <= RST_FLOOR;
         ceiling_ff     <= RST_CEILING;
         fail_limit_ff  <= RST_FAIL_LIMIT;
         commit_dly_ff  <= RST_COMMIT_DLY;
         preset_low_ff  <= RST_PRESET_LOW;
         preset_mid_ff  <= RST_PRESET_MID;
         preset_high_ff <= RST_PRESET_HIGH;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_STEP_SIZE:   step_size_ff   <= csr_wdata[STEP_WIDTH-1:0];
            CSR_FLOOR:       floor_ff       <= csr_wdata[TEMP_WIDTH-1:0];
            CSR_CEILING:     ceiling_ff     <= csr_wdata[TEMP_WIDTH-1:0];
            CSR_FAIL_LIMIT:  fail_limit_ff  <= csr_wdata[LIMIT_WIDTH-1:0];
            CSR_COMMIT_DLY:  commit_dly_ff  <= csr_wdata[LIMIT_WIDTH-1:0];
            CSR_PRESET_LOW:  preset_low_ff  <= csr_wdata[TEMP_WIDTH-1:0];
            CSR_PRESET_MID:  preset_mid_ff  <= csr_wdata[TEMP_WIDTH-1:0];
            CSR_PRESET_HIGH: preset_high_ff <= csr_wdata[TEMP_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         committed_ff <= RST_SETPOINT;
         edit_ff      <= RST_SETPOINT;
         hyst_ff      <= 1'b0;
         relay_ff     <= 1'b0;
         halt_ff      <= 1'b0;
         invalid_ff   <= '0;
         idle_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            committed_ff <= committed_in;
            edit_ff      <= edit_in;
            hyst_ff      <= hyst_in;
            relay_ff     <= relay_in;
            halt_ff      <= halt_in;
            invalid_ff   <= invalid_in;
            idle_ff      <= idle_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload needs no reset; load on every input transfer
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a latched halt never drops before reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt latch released without reset");

   // a halted result never drives the relay
   a_halt_relay_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.halted) |-> !rsp_data_ff.relay_on)
      else $error("relay driven while halted");

   // an empty result register always takes the next event
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input stalled with empty result register");

   // a button event while running clears the idle count
   a_button_clears_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !halt_ff && (op == OP_BUTTON)) |=> (idle_ff == '0))
      else $error("idle count not cleared by button");

   // a result appears only after an input transfer
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_fire))
      else $error("result without input transfer");

endmodule
